FILE: rtl/hfa_pkg.sv
`default_nettype none

package hfa_pkg;

  // Default sizes of the block.
  localparam int MAX_TAPS_DEF    = 64;
  localparam int SAMPLE_BITS_DEF = 16;
  localparam int COEF_BITS_DEF   = 16;

  // Fixed field widths of the tap count register and the coefficient index.
  localparam int TAP_CNT_W  = 6;
  localparam int COEF_IDX_W = 6;

  localparam logic [TAP_CNT_W-1:0] TAP_CNT_RST = 6'd63;

  // Transaction kinds on the input channel.
  localparam logic REQ_SAMPLE = 1'b0;
  localparam logic REQ_COEF   = 1'b1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_LOAD,
    ST_MUL,
    ST_ACC,
    ST_DONE
  } hfa_state_t;

  // Controls from the sequencer to the serial multiply-accumulate unit.
  typedef struct packed {
    logic clr_acc;
    logic load;
    logic step;
    logic last_bit;
    logic accum;
  } hfa_mac_ctl_t;

endpackage

`default_nettype wire

FILE: rtl/hilbert_fir_analytic_signal_core.sv
// Hilbert FIR analytic-signal generator.
// Input channel (in_valid / in_ready) carries two kinds of transaction. With
// in_req_type low it is a sample: the sample enters the delay line and exactly
// one result transaction follows. With in_req_type high it is a coefficient
// write of in_coef_value to tap in_coef_index; it gives no result, and an
// index at or beyond MAX_TAPS is dropped.
// Result channel (out_valid / out_ready): out_real_part is the sample delayed
// by half the tap count, out_imag_part the Q1.15 FIR sum, rounded and
// saturated. cfg_wr_en / cfg_wr_data set the tap count; the user must write
// it only while the block idles, as the block itself does not enforce this.
// Timing: the filter runs one shared bit-serial multiplier, one coefficient
// bit per cycle. A sample passes ST_READ, then ST_LOAD, ST_MUL and ST_ACC
// for each tap in use (once with no taps), then ST_DONE; in_ready is high
// only in ST_IDLE, so no new transaction is taken until the sample is done.
// Reset: after rst_n is released, both memories are swept to zero over all
// MAX_TAPS addresses with in_ready low; the tap count returns to 63.
// Stall: the result waits in an output register; the block still accepts and
// works on the next sample, and holds its finished result until the register
// frees up.
`default_nettype none

module hilbert_fir_analytic_signal_core #(
  parameter int MAX_TAPS    = hfa_pkg::MAX_TAPS_DEF,
  parameter int SAMPLE_BITS = hfa_pkg::SAMPLE_BITS_DEF,
  parameter int COEF_BITS   = hfa_pkg::COEF_BITS_DEF
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire logic                                  in_valid,
  output logic                                       in_ready,
  input  wire logic                                  in_req_type,
  input  wire logic signed [SAMPLE_BITS-1:0]         in_sample,
  input  wire logic        [hfa_pkg::COEF_IDX_W-1:0] in_coef_index,
  input  wire logic signed [COEF_BITS-1:0]           in_coef_value,
  output logic                                       out_valid,
  input  wire logic                                  out_ready,
  output logic signed      [SAMPLE_BITS-1:0]         out_real_part,
  output logic signed      [SAMPLE_BITS-1:0]         out_imag_part,
  input  wire logic                                  cfg_wr_en,
  input  wire logic        [hfa_pkg::TAP_CNT_W-1:0]  cfg_wr_data
);

  import hfa_pkg::*;

  localparam int IW  = $clog2(MAX_TAPS);
  localparam int BCW = $clog2(COEF_BITS);

  hfa_state_t state_r, state_nxt;

  logic [TAP_CNT_W-1:0] cfg_taps_r, cfg_taps_nxt;
  logic [IW-1:0]        ptr_r, ptr_nxt;
  logic [IW-1:0]        clr_r, clr_nxt;
  logic [IW-1:0]        haddr_r, haddr_nxt;
  logic [TAP_CNT_W-1:0] kc_r, kc_nxt;
  logic [TAP_CNT_W-1:0] last_idx_r, last_idx_nxt;
  logic [TAP_CNT_W-1:0] delay_r, delay_nxt;
  logic                 zero_r, zero_nxt;
  logic                 last_r, last_nxt;
  logic [BCW-1:0]       bc_r, bc_nxt;
  logic                 out_valid_r, out_valid_nxt;

  // Payload registers, no reset.
  logic signed [SAMPLE_BITS-1:0] real_r, real_nxt;
  logic signed [SAMPLE_BITS-1:0] out_real_r, out_real_nxt;
  logic signed [SAMPLE_BITS-1:0] out_imag_r, out_imag_nxt;

  logic                   accept;
  logic [TAP_CNT_W-1:0]   taps_eff;
  logic                   bit_last;

  logic                   hist_we;
  logic [IW-1:0]          hist_waddr;
  logic [SAMPLE_BITS-1:0] hist_wdata;
  logic [SAMPLE_BITS-1:0] hist_rdata;
  logic                   coef_we;
  logic [IW-1:0]          coef_waddr;
  logic [COEF_BITS-1:0]   coef_wdata;
  logic [COEF_BITS-1:0]   coef_rdata;

  hfa_mac_ctl_t                  mac_ctl;
  logic signed [SAMPLE_BITS-1:0] mac_imag;

  assign in_ready      = (state_r == ST_IDLE);
  assign accept        = in_valid && in_ready;
  assign out_valid     = out_valid_r;
  assign out_real_part = out_real_r;
  assign out_imag_part = out_imag_r;
  assign bit_last      = (bc_r == BCW'(COEF_BITS - 1));

  // A tap count beyond the table depth is clamped to the depth.
  always_comb begin
    if (int'(cfg_taps_r) > MAX_TAPS) begin
      taps_eff = TAP_CNT_W'(MAX_TAPS);
    end else begin
      taps_eff = cfg_taps_r;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cfg_taps_nxt  = cfg_taps_r;
    ptr_nxt       = ptr_r;
    clr_nxt       = clr_r;
    haddr_nxt     = haddr_r;
    kc_nxt        = kc_r;
    last_idx_nxt  = last_idx_r;
    delay_nxt     = delay_r;
    zero_nxt      = zero_r;
    last_nxt      = last_r;
    bc_nxt        = bc_r;
    real_nxt      = real_r;
    out_real_nxt  = out_real_r;
    out_imag_nxt  = out_imag_r;
    out_valid_nxt = out_valid_r && !out_ready;

    mac_ctl = '0;

    hist_we    = 1'b0;
    hist_waddr = ptr_r;
    hist_wdata = in_sample;
    coef_we    = 1'b0;
    coef_waddr = IW'(in_coef_index);
    coef_wdata = in_coef_value;

    if (cfg_wr_en) begin
      cfg_taps_nxt = cfg_wr_data;
    end

    case (state_r)
      ST_CLEAR: begin
        hist_we    = 1'b1;
        hist_waddr = clr_r;
        hist_wdata = '0;
        coef_we    = 1'b1;
        coef_waddr = clr_r;
        coef_wdata = '0;
        clr_nxt    = clr_r + 1'b1;
        if (clr_r == IW'(MAX_TAPS - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          if (in_req_type == REQ_COEF) begin
            coef_we = (int'(in_coef_index) < MAX_TAPS);
          end else begin
            // The sample is written now; the read of the newest entry
            // happens in the following cycle.
            hist_we         = 1'b1;
            haddr_nxt       = ptr_r;
            ptr_nxt         = (ptr_r == IW'(MAX_TAPS - 1)) ? '0 : ptr_r + 1'b1;
            kc_nxt          = '0;
            delay_nxt       = taps_eff >> 1;
            zero_nxt        = (taps_eff == '0);
            last_idx_nxt    = (taps_eff == '0) ? '0 : taps_eff - 1'b1;
            mac_ctl.clr_acc = 1'b1;
            state_nxt       = ST_READ;
          end
        end
      end
      ST_READ: begin
        state_nxt = ST_LOAD;
      end
      ST_LOAD: begin
        // Operands of tap kc_r are on the memory outputs. Advance the
        // addresses so the next tap is read during the multiply.
        mac_ctl.load = 1'b1;
        if (kc_r == delay_r) begin
          real_nxt = hist_rdata;
        end
        last_nxt  = (kc_r == last_idx_r);
        kc_nxt    = kc_r + 1'b1;
        haddr_nxt = (haddr_r == '0) ? IW'(MAX_TAPS - 1) : haddr_r - 1'b1;
        bc_nxt    = '0;
        state_nxt = ST_MUL;
      end
      ST_MUL: begin
        mac_ctl.step     = 1'b1;
        mac_ctl.last_bit = bit_last;
        bc_nxt           = bc_r + 1'b1;
        if (bit_last) begin
          state_nxt = ST_ACC;
        end
      end
      ST_ACC: begin
        // With no taps in use the single pass only fetches the real part.
        mac_ctl.accum = !zero_r;
        state_nxt     = last_r ? ST_DONE : ST_LOAD;
      end
      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_real_nxt  = real_r;
          out_imag_nxt  = mac_imag;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      cfg_taps_r  <= TAP_CNT_RST;
      ptr_r       <= '0;
      clr_r       <= '0;
      haddr_r     <= '0;
      kc_r        <= '0;
      last_idx_r  <= '0;
      delay_r     <= '0;
      zero_r      <= 1'b0;
      last_r      <= 1'b0;
      bc_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cfg_taps_r  <= cfg_taps_nxt;
      ptr_r       <= ptr_nxt;
      clr_r       <= clr_nxt;
      haddr_r     <= haddr_nxt;
      kc_r        <= kc_nxt;
      last_idx_r  <= last_idx_nxt;
      delay_r     <= delay_nxt;
      zero_r      <= zero_nxt;
      last_r      <= last_nxt;
      bc_r        <= bc_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    real_r     <= real_nxt;
    out_real_r <= out_real_nxt;
    out_imag_r <= out_imag_nxt;
  end

  // Delay line, addressed as a circular buffer.
  hfa_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (MAX_TAPS)
  ) u_hist_ram (
    .clk   (clk),
    .we    (hist_we),
    .waddr (hist_waddr),
    .wdata (hist_wdata),
    .raddr (haddr_r),
    .rdata (hist_rdata)
  );

  // Coefficient table.
  hfa_ram #(
    .WIDTH (COEF_BITS),
    .DEPTH (MAX_TAPS)
  ) u_coef_ram (
    .clk   (clk),
    .we    (coef_we),
    .waddr (coef_waddr),
    .wdata (coef_wdata),
    .raddr (IW'(kc_r)),
    .rdata (coef_rdata)
  );

  hfa_mac #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .COEF_BITS   (COEF_BITS),
    .MAX_TAPS    (MAX_TAPS)
  ) u_mac (
    .clk       (clk),
    .ctl       (mac_ctl),
    .hist_data (hist_rdata),
    .coef_data (coef_rdata),
    .imag      (mac_imag)
  );

endmodule

`default_nettype wire

FILE: rtl/hfa_ram.sv
`default_nettype none

module hfa_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

FILE: rtl/hfa_mac.sv
`default_nettype none

module hfa_mac #(
  parameter int SAMPLE_BITS = hfa_pkg::SAMPLE_BITS_DEF,
  parameter int COEF_BITS   = hfa_pkg::COEF_BITS_DEF,
  parameter int MAX_TAPS    = hfa_pkg::MAX_TAPS_DEF
) (
  input  wire logic                          clk,
  input  wire hfa_pkg::hfa_mac_ctl_t         ctl,
  input  wire logic signed [SAMPLE_BITS-1:0] hist_data,
  input  wire logic signed [COEF_BITS-1:0]   coef_data,
  output logic signed      [SAMPLE_BITS-1:0] imag
);

  import hfa_pkg::*;

  localparam int  PW      = SAMPLE_BITS + COEF_BITS;
  localparam int  ACC_RAW = SAMPLE_BITS + COEF_BITS + $clog2(MAX_TAPS);
  // The running sum is clamped at +-2^62 only when it could ever get there.
  localparam bit  SAT_EN  = (ACC_RAW > 64);
  localparam int  AW      = SAT_EN ? 64 : ACC_RAW;

  localparam logic signed [AW:0] RND  = (AW+1)'(1) << (COEF_BITS - 2);
  localparam logic signed [AW:0] Q_HI = ((AW+1)'(1) << (SAMPLE_BITS - 1)) - (AW+1)'(1);
  localparam logic signed [AW:0] Q_LO = -Q_HI - (AW+1)'(1);

  logic signed [PW-1:0]        mc_r, mc_nxt;
  logic        [COEF_BITS-1:0] mr_r, mr_nxt;
  logic signed [PW-1:0]        p_r, p_nxt;
  logic signed [AW-1:0]        acc_r, acc_nxt;

  logic signed [AW:0]   sum;
  logic signed [AW-1:0] sum_sat;
  logic signed [AW:0]   y;
  logic signed [AW:0]   q;

  assign sum = {acc_r[AW-1], acc_r} + {{(AW+1-PW){p_r[PW-1]}}, p_r};

  generate
    if (SAT_EN) begin : g_sat
      localparam logic signed [AW:0] LIM_HI = {{(AW-62){1'b0}}, 1'b1, 62'b0};
      localparam logic signed [AW:0] LIM_LO = -LIM_HI;
      always_comb begin
        if (sum > LIM_HI) begin
          sum_sat = LIM_HI[AW-1:0];
        end else if (sum < LIM_LO) begin
          sum_sat = LIM_LO[AW-1:0];
        end else begin
          sum_sat = sum[AW-1:0];
        end
      end
    end else begin : g_nosat
      assign sum_sat = sum[AW-1:0];
    end
  endgenerate

  // Shift-and-add multiply, one coefficient bit per cycle, LSB first.
  // The coefficient's sign bit carries negative weight, so it subtracts.
  always_comb begin
    mc_nxt  = mc_r;
    mr_nxt  = mr_r;
    p_nxt   = p_r;
    acc_nxt = acc_r;
    if (ctl.load) begin
      mc_nxt = {{COEF_BITS{hist_data[SAMPLE_BITS-1]}}, hist_data};
      mr_nxt = coef_data;
      p_nxt  = '0;
    end
    if (ctl.step) begin
      if (mr_r[0]) begin
        p_nxt = ctl.last_bit ? (p_r - mc_r) : (p_r + mc_r);
      end
      mc_nxt = mc_r <<< 1;
      mr_nxt = mr_r >> 1;
    end
    if (ctl.clr_acc) begin
      acc_nxt = '0;
    end
    if (ctl.accum) begin
      acc_nxt = sum_sat;
    end
  end

  always_ff @(posedge clk) begin
    mc_r  <= mc_nxt;
    mr_r  <= mr_nxt;
    p_r   <= p_nxt;
    acc_r <= acc_nxt;
  end

  // Round half up in Q1.15 terms, then clamp to the sample range.
  assign y = {acc_r[AW-1], acc_r} + RND;
  assign q = y >>> (COEF_BITS - 1);

  always_comb begin
    if (q > Q_HI) begin
      imag = Q_HI[SAMPLE_BITS-1:0];
    end else if (q < Q_LO) begin
      imag = Q_LO[SAMPLE_BITS-1:0];
    end else begin
      imag = q[SAMPLE_BITS-1:0];
    end
  end

endmodule

`default_nettype wire

FILE: verif/tb.sv
`timescale 1ns / 100ps

// Testbench for the Hilbert FIR analytic-signal core.
//
// Stimulus is queued by one initial block and handed to the block by a clocked
// driver. A clocked monitor takes the results. A scoreboard block keeps its
// own copy of the delay line, the coefficient table, the history pointer and
// the tap count. For every accepted sample transaction it computes the
// expected real and imaginary parts. The monitor compares each result
// transaction with the oldest prediction.
module tb;
  import hfa_pkg::*;

  localparam int NTAPS = MAX_TAPS_DEF;
  localparam int SW    = SAMPLE_BITS_DEF;
  localparam int CW    = COEF_BITS_DEF;
  localparam int PTR_W = $clog2(NTAPS);

  // The watchdog limit leaves room for the slowest sample, at 63 taps, plus
  // the long receiver hold-off several times over.
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int TAIL_CYCLES    = 1200;
  localparam int LONG_HOLD      = 1500;
  localparam int RANDOM_ITEMS   = 1630;

  typedef struct {
    logic                  req_type;
    logic signed [SW-1:0]  sample;
    logic [COEF_IDX_W-1:0] coef_index;
    logic signed [CW-1:0]  coef_value;
  } hfa_item_t;

  typedef struct {
    logic signed [SW-1:0] real_part;
    logic signed [SW-1:0] imag_part;
  } analytic_t;

  // Every input of the block starts at a known value.
  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic                  in_req_type = REQ_SAMPLE;
  logic signed [SW-1:0]  in_sample = '0;
  logic [COEF_IDX_W-1:0] in_coef_index = '0;
  logic signed [CW-1:0]  in_coef_value = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic signed [SW-1:0]  out_real_part;
  logic signed [SW-1:0]  out_imag_part;
  logic                  cfg_wr_en = 1'b0;
  logic [TAP_CNT_W-1:0]  cfg_wr_data = '0;

  // Transactions waiting to be offered, and predictions waiting for results.
  hfa_item_t offered_items[$];
  analytic_t analytic_due[$];

  // Idle rates in percent, set per phase by the stimulus process.
  int unsigned tx_idle_pct = 0;
  int unsigned rx_idle_pct = 0;

  // The stimulus process raises this flag; the monitor then holds out_ready
  // low while its own counter hold_left, loaded from LONG_HOLD, runs down.
  bit hold_request = 1'b0;
  int hold_left = 0;

  int mismatches = 0;
  int stall_cycles = 0;

  // Shadow state of the filter.
  logic signed [SW-1:0]  hist_model [NTAPS];
  logic signed [CW-1:0]  coef_model [NTAPS];
  logic [PTR_W-1:0]      hist_ptr;
  logic [TAP_CNT_W-1:0]  taps_model;

  hfa_item_t next_item;
  analytic_t want;

  hilbert_fir_analytic_signal_core #(
    .MAX_TAPS    (NTAPS),
    .SAMPLE_BITS (SW),
    .COEF_BITS   (CW)
  ) uut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_req_type   (in_req_type),
    .in_sample     (in_sample),
    .in_coef_index (in_coef_index),
    .in_coef_value (in_coef_value),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_real_part (out_real_part),
    .out_imag_part (out_imag_part),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Apply one accepted transaction to the shadow state. A coefficient write
  // only updates the table. A sample enters the delay line, and the FIR sum
  // over the taps in use is rounded half up, then saturated to 16 bits.
  task automatic hilbert_predict(input hfa_item_t it);
    int        n;
    int        dly;
    longint    acc;
    longint    rnd;
    analytic_t r;
    if (it.req_type == REQ_COEF) begin
      coef_model[it.coef_index] = it.coef_value;
    end else begin
      hist_model[hist_ptr] = it.sample;
      n = (int'(taps_model) > NTAPS) ? NTAPS : int'(taps_model);
      dly = n / 2;
      acc = 0;
      for (int k = 0; k < n; k++) begin
        acc += longint'(coef_model[k]) * longint'(hist_model[hist_ptr - PTR_W'(k)]);
      end
      // The arithmetic shift gives the floor, so adding half an LSB first
      // rounds half up for both signs.
      rnd = (acc + (longint'(1) <<< (CW - 2))) >>> (CW - 1);
      if (rnd > (longint'(1) <<< (SW - 1)) - 1) begin
        r.imag_part = {1'b0, {(SW - 1){1'b1}}};
      end else if (rnd < -(longint'(1) <<< (SW - 1))) begin
        r.imag_part = {1'b1, {(SW - 1){1'b0}}};
      end else begin
        r.imag_part = rnd[SW-1:0];
      end
      // With zero taps the delay is zero and the real part is the sample
      // just written.
      r.real_part = hist_model[hist_ptr - PTR_W'(dly)];
      analytic_due.push_back(r);
      hist_ptr = hist_ptr + 1'b1;
    end
  endtask

  // Scoreboard: tracks the register write and every accepted input
  // transaction. The reset sweep of the block leaves both memories at zero.
  always @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NTAPS; i++) begin
        hist_model[i] = '0;
        coef_model[i] = '0;
      end
      hist_ptr = '0;
      taps_model = TAP_CNT_RST;
      analytic_due.delete();
    end else begin
      if (cfg_wr_en) begin
        taps_model = cfg_wr_data;
      end
      if (in_valid && in_ready) begin
        hilbert_predict('{in_req_type, in_sample, in_coef_index, in_coef_value});
      end
    end
  end

  // Driver: a transaction stays on the bus unchanged until it is accepted.
  // When the bus is free, the next one is offered unless the sender idles.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (offered_items.size() > 0 && $urandom_range(99) >= tx_idle_pct) begin
        next_item = offered_items.pop_front();
        in_valid      <= 1'b1;
        in_req_type   <= next_item.req_type;
        in_sample     <= next_item.sample;
        in_coef_index <= next_item.coef_index;
        in_coef_value <= next_item.coef_value;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Monitor: checks each result transaction against the oldest prediction and
  // chooses out_ready for the next cycle.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      hold_left = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (analytic_due.size() == 0) begin
          $error("unexpected result: real_part %0d imag_part %0d",
                 out_real_part, out_imag_part);
          mismatches++;
        end else begin
          want = analytic_due.pop_front();
          if (out_real_part !== want.real_part) begin
            $error("real_part mismatch: expected %0d, got %0d",
                   want.real_part, out_real_part);
            mismatches++;
          end
          if (out_imag_part !== want.imag_part) begin
            $error("imag_part mismatch: expected %0d, got %0d",
                   want.imag_part, out_imag_part);
            mismatches++;
          end
        end
      end
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  // Watchdog: ends the run when no transaction moves on either channel for
  // too long.
  always @(posedge clk) begin
    if (!rst_n) begin
      stall_cycles <= 0;
    end else if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // Mostly full-range random values, with the two extremes and small
  // magnitudes mixed in.
  function automatic logic [15:0] pick_value16();
    case ($urandom_range(7))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'($urandom_range(127)) - 16'd64;
      default: return 16'($urandom);
    endcase
  endfunction

  // The unused fields of each transaction carry random values.
  task automatic queue_sample(input logic [SW-1:0] s);
    offered_items.push_back('{REQ_SAMPLE, s, COEF_IDX_W'($urandom), CW'($urandom)});
  endtask

  task automatic queue_coef(input logic [COEF_IDX_W-1:0] idx, input logic [CW-1:0] v);
    offered_items.push_back('{REQ_COEF, SW'($urandom), idx, v});
  endtask

  // Waits until nothing is queued, nothing is on the input bus and every
  // predicted result has arrived. A coefficient write gives no result, so the
  // task waits on after that until the block is surely idle.
  task automatic wait_block_idle();
    do @(negedge clk);
    while (offered_items.size() != 0 || in_valid || analytic_due.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  task automatic set_tap_count(input logic [TAP_CNT_W-1:0] taps);
    wait_block_idle();
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= taps;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  // Loads a Hilbert-shaped table: antisymmetric around the center tap, with
  // zeros at the center and at even offsets from it.
  task automatic queue_hilbert_table(input int n);
    int c;
    int v;
    c = n / 2;
    if (n > 0) begin
      queue_coef(COEF_IDX_W'(c), '0);
    end
    for (int m = 1; m <= c; m++) begin
      v = (m % 2 == 1) ? int'($urandom_range(65534)) - 32767 : 0;
      if (c + m < n) begin
        queue_coef(COEF_IDX_W'(c + m), CW'(v));
      end
      queue_coef(COEF_IDX_W'(c - m), CW'(-v));
    end
  endtask

  // One batch under a fresh tap count: mostly small odd counts, else short
  // ones of any parity, odd counts up to 31, or now and then the longest
  // filter with six loop items, as each sample there runs 63 taps serially.
  // The count returned includes the table writes, one per tap in use.
  task automatic run_random_batch(output int n_items);
    int unsigned          sel;
    logic [TAP_CNT_W-1:0] taps;
    int                   n_loop;
    sel = $urandom_range(99);
    if (sel < 70) begin
      taps = TAP_CNT_W'($urandom_range(1, 7) * 2 + 1);
    end else if (sel < 82) begin
      taps = TAP_CNT_W'($urandom_range(8));
    end else if (sel < 95) begin
      taps = TAP_CNT_W'($urandom_range(8, 15) * 2 + 1);
    end else begin
      taps = 6'd63;
    end
    set_tap_count(taps);
    n_loop = (taps > 31) ? 6 : int'($urandom_range(30, 70));
    n_items = n_loop;
    if ($urandom_range(1) == 1) begin
      queue_hilbert_table(int'(taps));
      n_items += int'(taps);
    end
    for (int i = 0; i < n_loop; i++) begin
      if ($urandom_range(9) == 0) begin
        if ($urandom_range(1) == 1 && taps > 0) begin
          queue_coef(COEF_IDX_W'($urandom_range(taps - 1)), pick_value16());
        end else begin
          queue_coef(COEF_IDX_W'($urandom), pick_value16());
        end
      end else begin
        queue_sample(pick_value16());
      end
    end
  endtask

  initial begin
    int issued;
    int batch;
    issued = 0;

    // Synchronous reset first; the block then sweeps its memories with
    // in_ready low, and the driver simply waits for it.
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // First phase: the sender idles now and then, the receiver mostly.
    tx_idle_pct = 29;
    rx_idle_pct = 75;

    // Full-length filter. The first sample sees an all-zero table. Then the
    // end taps get extreme values so the sum saturates in both directions.
    set_tap_count(6'd63);
    queue_sample(16'sh7fff);
    queue_coef(6'd0, 16'sh8000);
    queue_coef(6'd1, 16'sh7fff);
    queue_coef(6'd62, 16'sh8000);
    queue_coef(6'd63, 16'sh7fff);
    queue_sample(16'sh8000);
    queue_sample(16'sh8000);
    queue_sample(16'sh7fff);
    queue_sample(16'sh0000);
    queue_sample(16'shffff);

    // With zero taps the real part is the current sample and the imaginary
    // part is zero.
    set_tap_count(6'd0);
    queue_sample(16'sd1234);
    queue_sample(16'sh8000);

    // Tap counts below three, and an even one, are used as written.
    set_tap_count(6'd1);
    queue_sample(16'sh7fff);
    set_tap_count(6'd2);
    queue_sample(16'sd100);
    queue_sample(-16'sd200);
    set_tap_count(6'd4);
    queue_sample(16'sd5);
    queue_sample(-16'sd5);
    queue_sample(16'sh7fff);

    // Three-tap filter with a half-scale first tap: products of
    // exactly half an LSB show that rounding goes half up.
    set_tap_count(6'd3);
    queue_coef(6'd0, 16'sd16384);
    queue_coef(6'd1, 16'sd0);
    queue_coef(6'd2, 16'sd0);
    queue_sample(16'sd1);
    queue_sample(-16'sd1);
    queue_sample(16'sd3);

    // The receiver holds off for a long stretch while the sender keeps
    // offering, so the output register and the core fill and in_ready drops.
    set_tap_count(6'd3);
    hold_request = 1'b1;
    for (int i = 0; i < 40; i++) begin
      queue_sample(pick_value16());
    end
    issued += 40;

    while (issued < RANDOM_ITEMS / 3) begin
      run_random_batch(batch);
      issued += batch;
    end

    // Second phase: the idle rates swap sides.
    tx_idle_pct = 75;
    rx_idle_pct = 29;
    while (issued < 2 * RANDOM_ITEMS / 3) begin
      run_random_batch(batch);
      issued += batch;
    end

    // Third phase: no idling. Partway through, the sender pauses until every
    // predicted result has come back, then carries on under the same setting.
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    run_random_batch(batch);
    issued += batch;
    wait_block_idle();
    for (int i = 0; i < 30; i++) begin
      queue_sample(pick_value16());
    end
    issued += 30;
    while (issued < RANDOM_ITEMS) begin
      run_random_batch(batch);
      issued += batch;
    end

    // Drain, then give a stray extra result time to show up.
    wait_block_idle();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0 && analytic_due.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
